@@ rtl/tsm_pkg.sv @@
// Shared constants and types of the time-of-day scene schedule matcher.
`default_nettype none

package tsm_pkg;

	// Table geometry.
	localparam int MONTH_SLOTS       = 12;
	localparam int WINDOWS_PER_MONTH = 8;
	localparam int TABLE_SIZE        = MONTH_SLOTS * WINDOWS_PER_MONTH;

	// Field widths.
	localparam int SEC_W   = 17;
	localparam int MONTH_W = 4;
	localparam int SCENE_W = 4;
	localparam int SLOT_W  = 4;
	localparam int WSLOT_W = 3;

	// Window id width inside a cell: wide enough for every window and for the write field.
	localparam int WIN_IDW = ($clog2(WINDOWS_PER_MONTH) > WSLOT_W) ?
		$clog2(WINDOWS_PER_MONTH) : WSLOT_W;

	// Item modes.
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_TICK  = 1'b1;

	// Query token that moves down the row of cells, one cell a cycle.
	typedef struct packed {
		logic               valid;
		logic [MONTH_W-1:0] month;
		logic [SEC_W-1:0]   second;
		logic               found;
		logic [SCENE_W-1:0] scene;
	} tsm_tok_t;

	// Table write broadcast to every cell.
	typedef struct packed {
		logic               en;
		logic [SLOT_W-1:0]  month_slot;
		logic [WSLOT_W-1:0] window_slot;
		logic [MONTH_W-1:0] tag;
		logic [SEC_W-1:0]   win_start;
		logic [SEC_W-1:0]   win_stop;
		logic [SCENE_W-1:0] scene;
	} tsm_wr_t;

endpackage

`default_nettype wire

@@ rtl/tsm_ifs.sv @@
// Valid/ready channel interfaces for the command items and the result items.
`default_nettype none

interface tsm_cmd_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [3:0]  month_slot;
	logic [2:0]  window_slot;
	logic [3:0]  month_tag;
	logic [16:0] window_start;
	logic [16:0] window_end;
	logic [3:0]  window_scene;
	logic [3:0]  current_month;
	logic [16:0] current_second;
	logic        sink_accepts;

	modport source (
		output valid, mode, month_slot, window_slot, month_tag, window_start,
			window_end, window_scene, current_month, current_second, sink_accepts,
		input  ready
	);
	modport sink (
		input  valid, mode, month_slot, window_slot, month_tag, window_start,
			window_end, window_scene, current_month, current_second, sink_accepts,
		output ready
	);
endinterface

interface tsm_res_if;
	logic       valid;
	logic       ready;
	logic [3:0] scene;
	logic       active;
	logic       submit;
	logic       committed;

	modport source (
		output valid, scene, active, submit, committed,
		input  ready
	);
	modport sink (
		input  valid, scene, active, submit, committed,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/tsm_cell.sv @@
// One schedule window cell: stores a window and its slot tag, checks the passing query.
`default_nettype none

module tsm_cell (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [tsm_pkg::SLOT_W-1:0] slot_id,
	input  wire logic [tsm_pkg::WIN_IDW-1:0] win_id,
	input  wire tsm_pkg::tsm_wr_t           wr,
	input  wire tsm_pkg::tsm_tok_t          tok_in,
	output tsm_pkg::tsm_tok_t               tok_out
);
	import tsm_pkg::*;

	logic [MONTH_W-1:0] tag_q;
	logic [SEC_W-1:0]   start_q;
	logic [SEC_W-1:0]   stop_q;
	logic [SCENE_W-1:0] scene_q;
	logic               slot_sel;
	logic               win_sel;
	logic               ge_start;
	logic               lt_stop;
	logic               win_hit;
	logic               hit;
	logic               tok_valid_q;
	logic [MONTH_W-1:0] tok_month_q;
	logic [SEC_W-1:0]   tok_second_q;
	logic               tok_found_q;
	logic [SCENE_W-1:0] tok_scene_q;

	// Writes address this cell by its fixed slot and window position.
	assign slot_sel = wr.en && (wr.month_slot == slot_id);
	assign win_sel  = slot_sel && (WIN_IDW'(wr.window_slot) == win_id);

	// Table storage; the whole table clears at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q   <= '0;
			start_q <= '0;
			stop_q  <= '0;
			scene_q <= '0;
		end else begin
			if (slot_sel) begin
				tag_q <= wr.tag;
			end
			if (win_sel) begin
				start_q <= wr.win_start;
				stop_q  <= wr.win_stop;
				scene_q <= wr.scene;
			end
		end
	end

	// Window test: empty when start equals end, plain range or wrap past midnight.
	assign ge_start = (tok_in.second >= start_q);
	assign lt_stop  = (tok_in.second < stop_q);
	always_comb begin
		if (start_q == stop_q) begin
			win_hit = 1'b0;
		end else if (start_q < stop_q) begin
			win_hit = ge_start && lt_stop;
		end else begin
			win_hit = ge_start || lt_stop;
		end
	end

	// The first matching cell on the token's way claims it.
	assign hit = tok_in.valid && !tok_in.found && (tag_q == tok_in.month) && win_hit;

	// Token valid moves with reset; its payload needs none.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else begin
			tok_valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		tok_month_q  <= tok_in.month;
		tok_second_q <= tok_in.second;
		tok_found_q  <= tok_in.found || hit;
		tok_scene_q  <= hit ? scene_q : tok_in.scene;
	end

	assign tok_out.valid  = tok_valid_q;
	assign tok_out.month  = tok_month_q;
	assign tok_out.second = tok_second_q;
	assign tok_out.found  = tok_found_q;
	assign tok_out.scene  = tok_scene_q;

endmodule

`default_nettype wire

@@ rtl/time_of_day_scene_schedule_matcher.sv @@
// Top level: command decode, row of window cells, result and commit logic.
// A write item's result is ready in the cycle after the item is accepted.
// For a tick item the query walks the row of TABLE_SIZE window cells (12 slots of 8
// windows) one cell per cycle. One item is worked on at a time.
// Reset clears the whole schedule table, the committed scene and the enable bit at once.
`default_nettype none

module time_of_day_scene_schedule_matcher (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_we,
	input  wire logic  cfg_wdata,
	tsm_cmd_if.sink    cmd,
	tsm_res_if.source  res
);
	import tsm_pkg::*;

	logic               sched_en_q;
	logic               busy_q;
	logic               start_q;
	logic               res_valid_q;
	logic [MONTH_W-1:0] month_q;
	logic [SEC_W-1:0]   second_q;
	logic               acc_q;
	logic [SCENE_W-1:0] last_scene_q;
	logic               last_active_q;
	logic [SCENE_W-1:0] scene_q;
	logic               active_q;
	logic               submit_q;
	logic               committed_q;
	logic               cmd_acc;
	logic               done;
	logic [SCENE_W-1:0] fin_scene;
	logic               fin_active;
	logic               fin_diff;
	tsm_wr_t            wr;
	tsm_tok_t           tok [TABLE_SIZE+1];
	logic [TABLE_SIZE-1:0] tok_valid;

	// Handshake: one item at a time, and the result register must be free or read in the same cycle.
	assign cmd.ready = !busy_q && (!res_valid_q || res.ready);
	assign cmd_acc   = cmd.valid && cmd.ready;

	// Table write broadcast.
	assign wr.en          = cmd_acc && (cmd.mode == MODE_WRITE);
	assign wr.month_slot  = cmd.month_slot;
	assign wr.window_slot = cmd.window_slot;
	assign wr.tag         = cmd.month_tag;
	assign wr.win_start   = cmd.window_start;
	assign wr.win_stop    = cmd.window_end;
	assign wr.scene       = cmd.window_scene;

	// Query token entering the first cell.
	assign tok[0].valid  = start_q;
	assign tok[0].month  = month_q;
	assign tok[0].second = second_q;
	assign tok[0].found  = 1'b0;
	assign tok[0].scene  = '0;

	// Row of window cells, slot by slot, windows in order inside each slot.
	for (genvar m = 0; m < MONTH_SLOTS; m++) begin : g_slot
		for (genvar w = 0; w < WINDOWS_PER_MONTH; w++) begin : g_win
			localparam int K = m * WINDOWS_PER_MONTH + w;
			tsm_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.slot_id (SLOT_W'(m)),
				.win_id  (WIN_IDW'(w)),
				.wr      (wr),
				.tok_in  (tok[K]),
				.tok_out (tok[K+1])
			);
			assign tok_valid[K] = tok[K+1].valid;
		end
	end

	// Scan result with the enable gate, and the change against the committed pair.
	assign done       = tok[TABLE_SIZE].valid;
	assign fin_active = sched_en_q && tok[TABLE_SIZE].found;
	assign fin_scene  = fin_active ? tok[TABLE_SIZE].scene : '0;
	assign fin_diff   = (fin_scene != last_scene_q) || (fin_active != last_active_q);

	// Control state and committed pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sched_en_q    <= 1'b0;
			busy_q        <= 1'b0;
			start_q       <= 1'b0;
			res_valid_q   <= 1'b0;
			last_scene_q  <= '0;
			last_active_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (cfg_we) begin
				sched_en_q <= cfg_wdata;
			end
			if (res_valid_q && res.ready) begin
				res_valid_q <= 1'b0;
			end
			if (cmd_acc) begin
				if (cmd.mode == MODE_TICK) begin
					busy_q  <= 1'b1;
					start_q <= 1'b1;
				end else begin
					res_valid_q <= 1'b1;
				end
			end
			if (done) begin
				busy_q      <= 1'b0;
				res_valid_q <= 1'b1;
				if (fin_diff && acc_q) begin
					last_scene_q  <= fin_scene;
					last_active_q <= fin_active;
				end
			end
		end
	end

	// Tick capture and result payload.
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			month_q     <= cmd.current_month;
			second_q    <= cmd.current_second;
			acc_q       <= cmd.sink_accepts;
			scene_q     <= '0;
			active_q    <= 1'b0;
			submit_q    <= 1'b0;
			committed_q <= 1'b0;
		end
		if (done) begin
			scene_q     <= fin_scene;
			active_q    <= fin_active;
			submit_q    <= fin_diff;
			committed_q <= fin_diff && acc_q;
		end
	end

	assign res.valid     = res_valid_q;
	assign res.scene     = scene_q;
	assign res.active    = active_q;
	assign res.submit    = submit_q;
	assign res.committed = committed_q;

`ifndef SYNTHESIS
	// At most one query token is in the row.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(tok_valid) <= 1)
		else $error("more than one query token in the cell row");

	// A token in the row belongs to an open tick.
	a_token_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valid != '0) |-> busy_q)
		else $error("query token outside a tick");

	// A commit is always a submission.
	a_commit_submit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (!committed_q || submit_q))
		else $error("commit without submission");

	// A finished scan has a free result register.
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !res_valid_q)
		else $error("scan finished while a result still waits");
`endif

endmodule

`default_nettype wire
